// ===== hw/rtl/bda_pkg.sv =====
// Shared types and constants for the ARGB box-filter downsampler.
// Channel layout, configuration register codes and controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

  // Pixel layout: alpha, red, green, blue from the top byte down
  localparam int NUM_CH = 4;
  localparam int CH_W   = 8;
  localparam int PIX_W  = NUM_CH * CH_W;

  // Configuration register widths
  localparam int KS_W      = 5;
  localparam int OW_W      = 11;
  localparam int DX_W      = 15;
  localparam int DY_W      = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // Destination coordinate width
  localparam int DST_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_X0     = 2'd2,
    REG_Y0     = 2'd3
  } cfg_reg_t;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RMW  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

endpackage : bda_pkg

`default_nettype wire

// ===== hw/rtl/bda_line_mem.sv =====
// Line store of per-column block sums: one write port, one read port.
// Synchronous read: rdata is registered. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bda_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : bda_line_mem

`default_nettype wire

// ===== hw/rtl/bda_divider.sv =====
// Four-lane iterative restoring divider, one quotient bit per cycle.
// Keeps the low byte of each quotient. Uses bda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bda_divider #(
  parameter int SUM_W = 16,
  parameter int NW    = 9
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  input  wire logic [bda_pkg::NUM_CH-1:0][SUM_W-1:0]         sums,
  input  wire logic [NW-1:0]                                 divisor,
  output logic                                               busy,
  output logic      [bda_pkg::NUM_CH-1:0][bda_pkg::CH_W-1:0] quot
);

  import bda_pkg::*;

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic                               busy_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic [NW-1:0]                      n_r;
  logic [NUM_CH-1:0][SUM_W-1:0]       divd_r;
  logic [NUM_CH-1:0][NW-1:0]          rem_r;
  logic [NUM_CH-1:0][CH_W-1:0]        q_r;

  logic [NUM_CH-1:0][NW:0]            rsh;
  logic [NUM_CH-1:0]                  ge;

  // Shift the next dividend bit into each remainder and trial-compare
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rsh[c] = {rem_r[c], divd_r[c][SUM_W-1]};
      ge[c]  = (rsh[c] >= {1'b0, n_r});
    end
  end

  // Step counter: one step per dividend bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(SUM_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: load operands, then subtract and shift
  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= divisor;
      divd_r <= sums;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (ge[c]) begin
          rem_r[c] <= NW'(rsh[c] - {1'b0, n_r});
        end else begin
          rem_r[c] <= NW'(rsh[c]);
        end
        divd_r[c] <= divd_r[c] << 1;
        q_r[c]    <= {q_r[c][CH_W-2:0], ge[c]};
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule : bda_divider

`default_nettype wire

// ===== hw/rtl/box_downsample_argb_average.sv =====
// Box-filter downsampler: averages kernel x kernel blocks of ARGB pixels.
// A pixel inside a block row is taken while idle; a pixel ending a block row adds a
// read-modify-write step (line-store read, then add and write back). A pixel ending a
// block then starts the divider, and no pixel is taken until the quotients are done and
// the output register is free to load its word onto out_*.
// Synchronous rst_n resets counters, partial, config, out_valid; line store keeps data.
`timescale 1ns / 1ps
`default_nettype none

module box_downsample_argb_average #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_KERNEL    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Source pixel channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bda_pkg::PIX_W-1:0]       in_pixel_word,
  input  wire logic                            in_tile_start,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [bda_pkg::CH_W-1:0]        out_avg_alpha,
  output logic      [bda_pkg::CH_W-1:0]        out_avg_red,
  output logic      [bda_pkg::CH_W-1:0]        out_avg_green,
  output logic      [bda_pkg::CH_W-1:0]        out_avg_blue,
  output logic      [bda_pkg::DST_W-1:0]       out_dst_col,
  output logic      [bda_pkg::DST_W-1:0]       out_dst_row,
  output logic                                 out_row_done,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [bda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bda_pkg::CFG_W-1:0]       cfg_wdata
);

  import bda_pkg::*;

  localparam int KE_W  = $clog2(MAX_KERNEL + 1);
  localparam int WE_W  = $clog2(MAX_OUT_WIDTH + 1);
  localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int NW    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SUM_W = $clog2(255 * MAX_KERNEL * MAX_KERNEL + 1);
  localparam int ROW_W = DST_W;
  localparam int MEM_W = NUM_CH * SUM_W;

  // Configuration registers
  logic [KS_W-1:0]  kernel_size_r;
  logic [OW_W-1:0]  out_width_r;
  logic [DX_W-1:0]  dest_x0_r;
  logic [DY_W-1:0]  dest_y0_r;

  // Control and position state
  state_t                       state_r;
  logic [NUM_CH-1:0][SUM_W-1:0] partial_r;
  logic [KE_W-1:0]              sub_col_r;
  logic [KE_W-1:0]              sub_row_r;
  logic [COL_W-1:0]             out_col_r;
  logic [ROW_W-1:0]             out_row_r;

  // Coordinates of the block under division
  logic [DST_W-1:0]             meta_col_r;
  logic [DST_W-1:0]             meta_row_r;
  logic                         meta_done_r;

  // Output register
  logic                         out_valid_r;
  logic [NUM_CH-1:0][CH_W-1:0]  avg_r;
  logic [DST_W-1:0]             dst_col_r;
  logic [DST_W-1:0]             dst_row_r;
  logic                         row_done_r;

  // Combinational terms
  logic [31:0]                  k_ext;
  logic [31:0]                  w_ext;
  logic [KE_W-1:0]              k_eff;
  logic [WE_W-1:0]              w_eff;
  logic [2*KE_W-1:0]            kk;
  logic                         accept;
  logic                         clr;
  logic [KE_W-1:0]              sc_base;
  logic [KE_W-1:0]              sr_base;
  logic [COL_W-1:0]             oc_base;
  logic [ROW_W-1:0]             or_base;
  logic [NUM_CH-1:0][SUM_W-1:0] partial_sum;
  logic                         seg_end;
  logic [NUM_CH-1:0][SUM_W-1:0] rd_sums;
  logic [MEM_W-1:0]             rd_data;
  logic [NUM_CH-1:0][SUM_W-1:0] acc;
  logic                         col_last;
  logic                         row_last;
  logic [DST_W:0]               row_sum;
  logic                         div_start;
  logic                         div_busy;
  logic [NUM_CH-1:0][CH_W-1:0]  div_quot;
  logic                         out_free;
  logic                         out_load;

  // Clamp kernel size and width to their legal ranges
  always_comb begin
    k_ext = 32'(kernel_size_r);
    w_ext = 32'(out_width_r);
    if (kernel_size_r == '0) begin
      k_eff = KE_W'(1);
    end else if (k_ext > 32'(MAX_KERNEL)) begin
      k_eff = KE_W'(MAX_KERNEL);
    end else begin
      k_eff = KE_W'(k_ext);
    end
    if (out_width_r == '0) begin
      w_eff = WE_W'(1);
    end else if (w_ext > 32'(MAX_OUT_WIDTH)) begin
      w_eff = WE_W'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WE_W'(w_ext);
    end
    kk = (2*KE_W)'(k_eff) * (2*KE_W)'(k_eff);
  end

  // Take in a pixel: apply tile start, add channels into the partial
  always_comb begin
    accept  = in_valid && in_ready;
    clr     = in_tile_start;
    sc_base = clr ? '0 : sub_col_r;
    sr_base = clr ? '0 : sub_row_r;
    oc_base = clr ? '0 : out_col_r;
    or_base = clr ? '0 : out_row_r;
    for (int c = 0; c < NUM_CH; c++) begin
      partial_sum[c] = (clr ? '0 : partial_r[c])
                     + SUM_W'(in_pixel_word[CH_W*(NUM_CH-1-c) +: CH_W]);
    end
    seg_end = ((sc_base + KE_W'(1)) >= k_eff);
  end

  // Read-modify-write: fold the block row segment into the column sum
  always_comb begin
    rd_sums = rd_data;
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = ((sub_row_r == '0) ? '0 : rd_sums[c]) + partial_r[c];
    end
    col_last = ((WE_W'(out_col_r) + WE_W'(1)) >= w_eff);
    row_last = ((sub_row_r + KE_W'(1)) >= k_eff);
    row_sum  = (DST_W+1)'(dest_y0_r) + (DST_W+1)'(out_row_r);
    div_start = (state_r == ST_RMW) && row_last;
  end

  // Output register handoff
  always_comb begin
    out_free = !out_valid_r || out_ready;
    out_load = (state_r == ST_DIV) && !div_busy && out_free;
  end

  assign in_ready = (state_r == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_size_r <= KS_W'(1);
      out_width_r   <= OW_W'(1);
      dest_x0_r     <= '0;
      dest_y0_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KERNEL: kernel_size_r <= cfg_wdata[KS_W-1:0];
        REG_WIDTH:  out_width_r   <= cfg_wdata[OW_W-1:0];
        REG_X0:     dest_x0_r     <= cfg_wdata[DX_W-1:0];
        REG_Y0:     dest_y0_r     <= cfg_wdata[DY_W-1:0];
        default:    ;
      endcase
    end
  end

  // Sequencer and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      partial_r <= '0;
      sub_col_r <= '0;
      sub_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            partial_r <= partial_sum;
            sub_row_r <= sr_base;
            out_col_r <= oc_base;
            out_row_r <= or_base;
            if (seg_end) begin
              sub_col_r <= '0;
              state_r   <= ST_RMW;
            end else begin
              sub_col_r <= sc_base + KE_W'(1);
            end
          end
        end
        ST_RMW: begin
          partial_r <= '0;
          if (col_last) begin
            out_col_r <= '0;
            if (row_last) begin
              sub_row_r <= '0;
              if (out_row_r != '1) begin
                out_row_r <= out_row_r + ROW_W'(1);
              end
            end else begin
              sub_row_r <= sub_row_r + KE_W'(1);
            end
          end else begin
            out_col_r <= out_col_r + COL_W'(1);
          end
          state_r <= row_last ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Hold destination coordinates of the block being divided
  always_ff @(posedge clk) begin
    if (div_start) begin
      meta_col_r  <= DST_W'(DST_W'(dest_x0_r) + DST_W'(out_col_r));
      meta_row_r  <= row_sum[DST_W] ? '1 : row_sum[DST_W-1:0];
      meta_done_r <= col_last;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_r      <= div_quot;
      dst_col_r  <= meta_col_r;
      dst_row_r  <= meta_row_r;
      row_done_r <= meta_done_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_avg_alpha = avg_r[0];
  assign out_avg_red   = avg_r[1];
  assign out_avg_green = avg_r[2];
  assign out_avg_blue  = avg_r[3];
  assign out_dst_col   = dst_col_r;
  assign out_dst_row   = dst_row_r;
  assign out_row_done  = row_done_r;

  bda_line_mem #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (COL_W),
    .DW    (MEM_W)
  ) u_line_mem (
    .clk   (clk),
    .we    (state_r == ST_RMW),
    .waddr (out_col_r),
    .wdata (acc),
    .re    (accept && seg_end),
    .raddr (oc_base),
    .rdata (rd_data)
  );

  bda_divider #(
    .SUM_W (SUM_W),
    .NW    (NW)
  ) u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .sums    (acc),
    .divisor (NW'(kk)),
    .busy    (div_busy),
    .quot    (div_quot)
  );

endmodule : box_downsample_argb_average

`default_nettype wire

// ===== verif/box_downsample_argb_average_test.sv =====
// Self-checking testbench for box_downsample_argb_average: block averages and coordinates.
// A directed table runs first, then random tiles under several idle patterns.
// Depends on bda_pkg and the box_downsample_argb_average RTL only.
`timescale 1ns / 1ps

module box_downsample_argb_average_test;
  import bda_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_K = 16;
  localparam int RAND_ITEMS = 725;
  localparam int PHASE_ITEMS = 260;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 100;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SEND_IDLE [4] = '{0, 60, 0, 28};
  localparam int unsigned RCV_STALL [4] = '{0, 0, 60, 28};

  // One averaged output word
  typedef struct packed {
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [DST_W-1:0] col;
    logic [DST_W-1:0] row;
    logic             row_end;
  } avg_word_t;

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    cfg_reg_t         addr;
    logic [CFG_W-1:0] wdata;
    logic [PIX_W-1:0] pix;
    logic             ts;
    logic             typed;
    avg_word_t        want;
  } stim_row_t;

  localparam avg_word_t NO_AVG = '0;
  localparam int N_DIR = 29;

  // Directed table: register writes happen with the block drained
  localparam stim_row_t DIRECTED [N_DIR] = '{
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0000_0000, 1'b1, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b1}},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'h0001, 1'b1}},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h1234_5678, 1'b0, 1'b1,
      '{8'h12, 8'h34, 8'h56, 8'h78, 16'h0000, 16'h0002, 1'b1}},
    // zero kernel and zero width both act as one
    '{ROW_WRITE, REG_KERNEL, 15'h0000, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_WRITE, REG_WIDTH,  15'h0000, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_WRITE, REG_X0,     15'h7FFF, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_WRITE, REG_Y0,     15'h7FFF, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h80FF_0001, 1'b1, 1'b1,
      '{8'h80, 8'hFF, 8'h00, 8'h01, 16'h7FFF, 16'h7FFF, 1'b1}},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0102_0304, 1'b0, 1'b1,
      '{8'h01, 8'h02, 8'h03, 8'h04, 16'h7FFF, 16'h8000, 1'b1}},
    // 2x2 blocks, two output columns
    '{ROW_WRITE, REG_KERNEL, 15'h0002, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_WRITE, REG_WIDTH,  15'h0002, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0000_0000, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0000_0000, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b0}},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0000_0001, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0000_0003, 1'b0, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h01, 16'h8000, 16'h7FFF, 1'b1}},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h8080_8080, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h7F7F_7F7F, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0101_0101, 1'b0, 1'b0, NO_AVG},
    // shrink the width in the middle of a block row, column counter past it
    '{ROW_WRITE, REG_WIDTH,  15'h0001, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0101_0101, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hFEFE_FEFE, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0000_0000, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'h0F0F_0F0F, 1'b0, 1'b0, NO_AVG},
    // shrink the kernel in the middle of a block
    '{ROW_WRITE, REG_KERNEL, 15'h0001, 32'h0, 1'b0, 1'b0, NO_AVG},
    '{ROW_PIXEL, REG_KERNEL, 15'h0, 32'hF0F0_F0F0, 1'b0, 1'b0, NO_AVG}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_word;
  logic                 in_tile_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [CH_W-1:0]      out_avg_alpha;
  logic [CH_W-1:0]      out_avg_red;
  logic [CH_W-1:0]      out_avg_green;
  logic [CH_W-1:0]      out_avg_blue;
  logic [DST_W-1:0]     out_dst_col;
  logic [DST_W-1:0]     out_dst_row;
  logic                 out_row_done;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Predictor copy of the registers and the averaging state
  logic [KS_W-1:0] ksize;
  logic [OW_W-1:0] owidth;
  logic [DX_W-1:0] org_x;
  logic [DY_W-1:0] org_y;
  int unsigned line_sum [MAX_W][NUM_CH];
  int unsigned seg_sum [NUM_CH];
  int unsigned px_in_blk, ln_in_blk, blk_x, blk_y;

  avg_word_t pending_avgs [$];
  avg_word_t head_avg;
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned rand_pixels = 0;
  bit hold_req = 1'b0;
  longint cycles = 0;

  box_downsample_argb_average #(
    .MAX_OUT_WIDTH(MAX_W),
    .MAX_KERNEL   (MAX_K)
  ) dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_kernel();
    if (ksize == 0) return 1;
    return (ksize > MAX_K) ? MAX_K : ksize;
  endfunction

  function automatic int unsigned eff_width();
    if (owidth == 0) return 1;
    return (owidth > MAX_W) ? MAX_W : owidth;
  endfunction

  // Accumulate one pixel; return 1 with the averaged word when it closes a block
  function automatic bit average_block(input logic [PIX_W-1:0] pix, input logic ts,
                                       output avg_word_t res);
    int unsigned k, w, n, dst;
    int unsigned acc [NUM_CH];
    bit hit;
    k = eff_kernel();
    w = eff_width();
    res = '0;
    hit = 1'b0;
    if (ts) begin
      seg_sum = '{default: 0};
      px_in_blk = 0;
      ln_in_blk = 0;
      blk_x = 0;
      blk_y = 0;
    end
    for (int c = 0; c < NUM_CH; c++) seg_sum[c] += pix[PIX_W-1-CH_W*c -: CH_W];
    if (px_in_blk + 1 < k) begin
      px_in_blk++;
      return 1'b0;
    end
    // fold the segment into the column sum
    for (int c = 0; c < NUM_CH; c++) begin
      acc[c] = ((ln_in_blk == 0) ? 0 : line_sum[blk_x][c]) + seg_sum[c];
      line_sum[blk_x][c] = acc[c];
      seg_sum[c] = 0;
    end
    px_in_blk = 0;
    if (ln_in_blk + 1 >= k) begin
      n = k * k;
      res.alpha = CH_W'(acc[0] / n);
      res.red = CH_W'(acc[1] / n);
      res.green = CH_W'(acc[2] / n);
      res.blue = CH_W'(acc[3] / n);
      res.col = DST_W'(org_x + blk_x);
      dst = org_y + blk_y;
      res.row = (dst > 65535) ? 16'hFFFF : DST_W'(dst);
      res.row_end = (blk_x + 1 >= w);
      hit = 1'b1;
    end
    // advance column, then block row, then output row
    if (blk_x + 1 >= w) begin
      blk_x = 0;
      if (ln_in_blk + 1 >= k) begin
        ln_in_blk = 0;
        if (blk_y < 65535) blk_y++;
      end else begin
        ln_in_blk++;
      end
    end else begin
      blk_x++;
    end
    return hit;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '1;
      1: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_origin();
    case ($urandom_range(5))
      0: return '0;
      1: return 15'h7FFF;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Offer one pixel word, hold it until taken, then predict its result
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic ts,
                            input logic typed, input avg_word_t want);
    avg_word_t res;
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_word <= pix;
    in_tile_start <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    hit = average_block(pix, ts, res);
    if (typed) pending_avgs.push_back(want);
    else if (hit) pending_avgs.push_back(res);
  endtask

  // Drop valid, drain every expected word, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_avgs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t addr, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_KERNEL: ksize = data[KS_W-1:0];
      REG_WIDTH:  owidth = data[OW_W-1:0];
      REG_X0:     org_x = data[DX_W-1:0];
      REG_Y0:     org_y = data[DY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic note_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // Compare each taken word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_avgs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got col 0x%0h row 0x%0h",
                   $time, out_dst_col, out_dst_row);
      end else begin
        head_avg = pending_avgs.pop_front();
        note_field("avg_alpha", head_avg.alpha, out_avg_alpha);
        note_field("avg_red", head_avg.red, out_avg_red);
        note_field("avg_green", head_avg.green, out_avg_green);
        note_field("avg_blue", head_avg.blue, out_avg_blue);
        note_field("dst_col", head_avg.col, out_dst_col);
        note_field("dst_row", head_avg.row, out_dst_row);
        note_field("row_done", head_avg.row_end, out_row_done);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase, mode, kv, wv, rows, tiles, per_tile, cut, phase_start;
    logic [CFG_W-1:0] word;
    logic ts;
    bit big, pause;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_word = '0;
    in_tile_start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KERNEL;
    cfg_wdata = '0;
    ksize = 1;
    owidth = 1;
    org_x = '0;
    org_y = '0;
    seg_sum = '{default: 0};
    px_in_blk = 0;
    ln_in_blk = 0;
    blk_x = 0;
    blk_y = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        settle();
        write_reg(DIRECTED[i].addr, DIRECTED[i].wdata);
      end else begin
        send_pixel(DIRECTED[i].pix, DIRECTED[i].ts, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random phases: phase 1 is the largest kernel, phase 3 opens the widest row;
    // each phase sends at most PHASE_ITEMS pixels
    phase = 0;
    while (rand_pixels < RAND_ITEMS) begin
      settle();
      mode = phase % 4;
      send_idle_pct = SEND_IDLE[mode];
      rcv_stall_pct = RCV_STALL[mode];
      big = (phase == 1) || (phase == 3);
      if (phase == 1) kv = 31;
      else if (phase == 0 || phase == 3) kv = 1;
      else kv = $urandom_range(0, 5);
      if (phase == 1) wv = 1;
      else if (phase == 3) wv = 2047;
      else if (phase == 0) wv = 6;
      else wv = $urandom_range(0, 8);
      // upper data bits beyond the register width must be dropped
      word = CFG_W'(kv);
      if ($urandom_range(3) == 0) word |= CFG_W'($urandom) & 15'h7FE0;
      write_reg(REG_KERNEL, word);
      word = CFG_W'(wv);
      if ($urandom_range(3) == 0) word |= CFG_W'($urandom) & 15'h7800;
      write_reg(REG_WIDTH, word);
      write_reg(REG_X0, pick_origin());
      write_reg(REG_Y0, pick_origin());
      pause = (phase % 3 == 1) || (phase % 5 == 2);
      // hold off the receiver while words keep coming, so the input stalls
      if (phase == 0) hold_req = 1'b1;
      phase_start = rand_pixels;
      tiles = big ? 1 : ((phase == 0) ? 3 : $urandom_range(1, 3));
      for (int t = 0; t < tiles; t++) begin
        rows = big ? 1 : ((phase == 0) ? 3 : $urandom_range(1, 3));
        per_tile = eff_width() * eff_kernel() * eff_kernel() * rows;
        cut = ($urandom_range(7) == 0) ? $urandom_range(1, per_tile) : per_tile;
        for (int i = 0; i < cut && rand_pixels < RAND_ITEMS &&
             rand_pixels - phase_start < PHASE_ITEMS; i++) begin
          // pause mid-tile until drained; sometimes shrink a limit there
          if (pause && t == 0 && i > 0 && i == per_tile / 2) begin
            settle();
            if (phase % 5 == 2) begin
              if ($urandom_range(1) == 1)
                write_reg(REG_KERNEL, CFG_W'($urandom_range(1, eff_kernel())));
              else
                write_reg(REG_WIDTH, CFG_W'($urandom_range(1, eff_width())));
            end
          end
          ts = (i == 0) || ($urandom_range(49) == 0);
          send_pixel(pick_pixel(), ts, 1'b0, NO_AVG);
          rand_pixels++;
        end
      end
      phase++;
    end
    settle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bda_pkg.sv
hw/rtl/bda_line_mem.sv
hw/rtl/bda_divider.sv
hw/rtl/box_downsample_argb_average.sv
verif/box_downsample_argb_average_test.sv
